>>> rtl/core/servo_bus_packet_framer_macros.svh
// assertion macros for the servo bus packet framer
`ifndef SERVO_BUS_PACKET_FRAMER_MACROS_SVH
`define SERVO_BUS_PACKET_FRAMER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define SBPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbpf assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define SBPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbpf assertion failed");
`else
`define SBPF_ASSERT_IMP(lbl, ante, cons)
`define SBPF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/sbpf_pkg.sv
// shared types and constants of the servo bus packet framer
package sbpf_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;
    typedef logic [3:0]  step_t;

    // configuration port
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DEVICE_ID    = 2'd0;
    localparam cfg_idx_t CFG_PROTOCOL_TWO = 2'd1;

    localparam byte_t DEVICE_ID_RESET = 8'd1;

    // item kinds
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_PARAM = 1'b1
    } func_t;

    // framing constants
    localparam byte_t SYNC_BYTE   = 8'hFF;
    localparam byte_t P2_HDR_FD   = 8'hFD;
    localparam byte_t P2_RESERVED = 8'h00;
    localparam crc_t  CRC_POLY    = 16'h8005;
    localparam byte_t LEN_ADD_P2  = 8'd3;
    localparam byte_t LEN_ADD_P1  = 8'd2;
    localparam step_t HDR_LEN_P2  = 4'd8;
    localparam step_t HDR_LEN_P1  = 4'd5;

    // one accepted item waiting for the byte sequencer
    typedef struct packed {
        logic  valid;
        logic  func;
        logic  proto2;
        logic  with_check;
        byte_t dev_id;
        byte_t inst;
        byte_t count;
        byte_t pbyte;
    } item_t;

endpackage

>>> rtl/core/sbpf_cmd_if.sv
// command channel: start and parameter words into the framer
interface sbpf_cmd_if;
    import sbpf_pkg::*;

    logic  valid;
    logic  ready;
    logic  func;
    byte_t instruction_code;
    byte_t param_count;
    byte_t param_byte;

    modport source (output valid, output func, output instruction_code,
                    output param_count, output param_byte, input ready);
    modport sink   (input valid, input func, input instruction_code,
                    input param_count, input param_byte, output ready);
endinterface

>>> rtl/core/sbpf_txd_if.sv
// byte channel: framed packet bytes toward the uart
interface sbpf_txd_if;
    import sbpf_pkg::*;

    logic  valid;
    logic  ready;
    byte_t tx_byte;
    logic  end_of_packet;
    logic  last_of_run;

    modport source (output valid, output tx_byte, output end_of_packet,
                    output last_of_run, input ready);
    modport sink   (input valid, input tx_byte, input end_of_packet,
                    input last_of_run, output ready);
endinterface

>>> rtl/core/servo_bus_packet_framer.sv
// Servo bus instruction packet framer. Each word on cmd is either a start
// (func 0: instruction and parameter count) or one parameter byte (func 1);
// each word on txd is one byte of the framed packet. Protocol 2 frames as
// FF FF FD 00 ID LEN_L LEN_H INST params CRC_L CRC_H (CRC-16 0x8005, init 0,
// MSB first), protocol 1 as FF FF ID LEN INST params ~SUM. The byte sequencer
// puts out one byte per cycle into a single output register while txd is
// ready; a start gives 8 header bytes (5 under protocol 1), plus 2 (or 1)
// check bytes when the count is zero, and a parameter its byte, plus those on
// the last one of a packet. A parameter with no open packet is taken and gives
// nothing. The next command word is taken in the same cycle the previous one's
// last byte is loaded, so bytes stream without gaps while txd keeps up. The
// user must write configuration through cfg_we/cfg_index/cfg_data only while
// the block is idle, not enforced here. Reset leaves device_id 1 and protocol 2.
`include "servo_bus_packet_framer_macros.svh"

module servo_bus_packet_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  sbpf_pkg::cfg_idx_t cfg_index,
    input  sbpf_pkg::byte_t    cfg_data,
    sbpf_cmd_if.sink           cmd,
    sbpf_txd_if.source         txd
);
    import sbpf_pkg::*;

    // configuration registers
    byte_t device_id_reg;
    logic  protocol_two_reg;

    // item handed from intake to the sequencer
    item_t item;
    logic  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg    <= DEVICE_ID_RESET;
            protocol_two_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ID:    device_id_reg    <= cfg_data;
                CFG_PROTOCOL_TWO: protocol_two_reg <= cfg_data[0];
                default:          ; // unused indexes are ignored
            endcase
        end
    end

    // packet bookkeeping happens as words arrive; stray parameters die here
    sbpf_intake u_intake (
        .clk          (clk),
        .rst_n        (rst_n),
        .device_id    (device_id_reg),
        .protocol_two (protocol_two_reg),
        .cmd          (cmd),
        .take         (take),
        .item         (item)
    );

    // running crc and sum live next to the byte they cover
    sbpf_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .txd   (txd)
    );

    // the final check byte always closes the run of its word
    `SBPF_ASSERT_IMP(a_eop_is_last, txd.valid && txd.end_of_packet, txd.last_of_run)
    // retiring an item puts its last byte on the output next cycle
    `SBPF_ASSERT_NXT(a_take_shows_last, take, txd.valid && txd.last_of_run)
    // a stalled output register holds the sequencer back
    `SBPF_ASSERT_IMP(a_stall_blocks_take, txd.valid && !txd.ready, !take)

endmodule

>>> rtl/core/sbpf_intake.sv
// input stage: packet bookkeeping and the item register
module sbpf_intake (
    input  logic           clk,
    input  logic           rst_n,
    input  sbpf_pkg::byte_t device_id,
    input  logic           protocol_two,
    sbpf_cmd_if.sink       cmd,
    input  logic           take,
    output sbpf_pkg::item_t item
);
    import sbpf_pkg::*;

    logic  packet_open_reg, packet_open_next;
    byte_t params_left_reg, params_left_next;
    logic  item_valid_reg, item_valid_next;
    item_t item_reg;
    item_t load;
    logic  accept;
    logic  is_start;

    assign cmd.ready = !item_valid_reg || take;
    assign accept    = cmd.valid && cmd.ready;
    assign is_start  = (cmd.func == FUNC_START);

    always_comb
    begin
        packet_open_next = packet_open_reg;
        params_left_next = params_left_reg;
        item_valid_next  = item_valid_reg && !take;

        load.valid      = 1'b1;
        load.func       = cmd.func;
        load.proto2     = protocol_two;
        load.dev_id     = device_id;
        load.inst       = cmd.instruction_code;
        load.count      = cmd.param_count;
        load.pbyte      = cmd.param_byte;
        load.with_check = 1'b0;

        if (accept)
        begin
            if (is_start)
            begin
                // a new start abandons whatever was open
                load.with_check  = (cmd.param_count == 8'd0);
                packet_open_next = (cmd.param_count != 8'd0);
                params_left_next = cmd.param_count;
                item_valid_next  = 1'b1;
            end
            else if (packet_open_reg)
            begin
                load.with_check  = (params_left_reg == 8'd1);
                packet_open_next = (params_left_reg != 8'd1);
                params_left_next = params_left_reg - 8'd1;
                item_valid_next  = 1'b1;
            end
            // stray parameter: dropped, nothing loaded
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_open_reg <= 1'b0;
            params_left_reg <= 8'd0;
            item_valid_reg  <= 1'b0;
        end
        else
        begin
            packet_open_reg <= packet_open_next;
            params_left_reg <= params_left_next;
            item_valid_reg  <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= load;
        end
    end

    always_comb
    begin
        item       = item_reg;
        item.valid = item_valid_reg;
    end

endmodule

>>> rtl/core/sbpf_emit.sv
// byte sequencer: header, parameter and check bytes into the output register
module sbpf_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  sbpf_pkg::item_t item,
    output logic            take,
    sbpf_txd_if.source      txd
);
    import sbpf_pkg::*;

    localparam step_t SUM_FROM_P2 = 4'd4;
    localparam step_t SUM_FROM_P1 = 4'd2;

    step_t step_reg, step_next;
    crc_t  crc_reg, crc_next;
    byte_t sum_reg, sum_next;
    logic  out_valid_reg, out_valid_next;
    byte_t tx_byte_reg;
    logic  eop_reg;
    logic  last_reg;

    logic  gen;
    logic  is_start;
    logic  first;
    logic  in_check;
    logic  add_sum;
    logic  at_last;
    step_t base_cnt;
    step_t chk_cnt;
    step_t last_step;
    byte_t cur_byte;
    crc_t  crc_base;
    byte_t sum_base;

    function automatic crc_t crc_byte(crc_t crc, byte_t b);
        crc_t c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic byte_t hdr_byte(logic p2, step_t s, byte_t id, byte_t inst,
                                       byte_t cnt);
        logic [8:0] len;
        byte_t      b;
        len = {1'b0, cnt} + {1'b0, (p2 ? LEN_ADD_P2 : LEN_ADD_P1)};
        b   = inst;
        if (p2)
        begin
            case (s) inside
                4'd0, 4'd1: b = SYNC_BYTE;
                4'd2:       b = P2_HDR_FD;
                4'd3:       b = P2_RESERVED;
                4'd4:       b = id;
                4'd5:       b = len[7:0];
                4'd6:       b = {7'd0, len[8]};
                default:    b = inst;
            endcase
        end
        else
        begin
            case (s) inside
                4'd0, 4'd1: b = SYNC_BYTE;
                4'd2:       b = id;
                4'd3:       b = len[7:0];
                default:    b = inst;
            endcase
        end
        return b;
    endfunction

    always_comb
    begin
        is_start  = (item.func == FUNC_START);
        base_cnt  = is_start ? (item.proto2 ? HDR_LEN_P2 : HDR_LEN_P1) : 4'd1;
        chk_cnt   = item.with_check ? (item.proto2 ? 4'd2 : 4'd1) : 4'd0;
        last_step = base_cnt + chk_cnt - 4'd1;
        in_check  = (step_reg >= base_cnt);
        at_last   = (step_reg == last_step);
        first     = is_start && (step_reg == 4'd0);

        gen  = item.valid && (!out_valid_reg || txd.ready);
        take = gen && at_last;

        // check bytes never feed the running checks: the next start clears them
        if (in_check)
        begin
            if (item.proto2)
            begin
                cur_byte = (step_reg == base_cnt) ? crc_reg[7:0] : crc_reg[15:8];
            end
            else
            begin
                cur_byte = ~sum_reg;
            end
        end
        else if (is_start)
        begin
            cur_byte = hdr_byte(item.proto2, step_reg, item.dev_id, item.inst, item.count);
        end
        else
        begin
            cur_byte = item.pbyte;
        end

        add_sum = !in_check &&
                  (!is_start || (step_reg >= (item.proto2 ? SUM_FROM_P2 : SUM_FROM_P1)));

        crc_base = first ? 16'd0 : crc_reg;
        sum_base = first ? 8'd0 : sum_reg;
        crc_next = crc_reg;
        sum_next = sum_reg;
        if (gen && !in_check)
        begin
            crc_next = crc_byte(crc_base, cur_byte);
            sum_next = add_sum ? (sum_base + cur_byte) : sum_base;
        end

        step_next = step_reg;
        if (gen)
        begin
            step_next = at_last ? 4'd0 : (step_reg + 4'd1);
        end

        out_valid_next = gen || (out_valid_reg && !txd.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            crc_reg       <= 16'd0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            tx_byte_reg <= cur_byte;
            eop_reg     <= in_check && at_last;
            last_reg    <= at_last;
        end
    end

    assign txd.valid         = out_valid_reg;
    assign txd.tx_byte       = tx_byte_reg;
    assign txd.end_of_packet = eop_reg;
    assign txd.last_of_run   = last_reg;

endmodule
